// File: src/nir_pkg.sv
`default_nettype none

package nir_pkg;

  localparam int unsigned MaxRepeatsDefault = 15;
  localparam int unsigned DataBits          = 32;
  localparam int unsigned BitCntW           = $clog2(DataBits);

  localparam logic [12:0] HdrMark   = 13'd4500;
  localparam logic [12:0] BitMark   = 13'd281;
  localparam logic [15:0] HdrSpace  = 16'd2250;
  localparam logic [15:0] OneSpace  = 16'd844;
  localparam logic [15:0] ZeroSpace = 16'd281;
  localparam logic [15:0] FirstGap  = 16'd20000;
  localparam logic [15:0] LaterGap  = 16'd48094;
  localparam logic [15:0] RptSpace  = 16'd1125;

  typedef struct packed {
    logic [15:0] address;
    logic        extended;
    logic [7:0]  command;
    logic [7:0]  repeats;
  } req_t;

  typedef struct packed {
    logic [12:0] mark_units;
    logic [15:0] space_units;
    logic        last;
    logic        error;
  } res_t;

  typedef struct packed {
    logic load;
    logic shift;
  } sh_ctl_t;

  typedef struct packed {
    logic data_bit;
    logic final_bit;
  } sh_stat_t;

endpackage

`default_nettype wire

// File: src/nir_shift.sv
`default_nettype none

module nir_shift (
  input  wire                              clk,
  input  wire                              rst,
  input  nir_pkg::sh_ctl_t                 ctl,
  input  wire [nir_pkg::DataBits-1:0]      word,
  output nir_pkg::sh_stat_t                stat
);
  import nir_pkg::*;

  logic [DataBits-1:0] sreg;
  logic [BitCntW-1:0]  cnt;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sreg <= word;
    end else if (ctl.shift) begin
      sreg <= {1'b0, sreg[DataBits-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.shift) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.data_bit  = sreg[0];
  assign stat.final_bit = (cnt == BitCntW'(DataBits - 1));

endmodule

`default_nettype wire

// File: src/nec_ir_frame_pulse_encoder.sv
// The first mark/space pair appears in the cycle after a request is accepted.
// One pair per cycle; a request with R repeats gives 34 + 2*R pairs, and
// busy stays high for all pairs but the last; a new request is taken only when idle.
// The pace is set by the one-bit-per-cycle data shift register.
// A request with too many repeats gives one error result next cycle, busy stays low.
// Reset (rst, synchronous) returns the sequencer to idle and drops strobe at once.
`default_nettype none

module nec_ir_frame_pulse_encoder #(
  parameter int unsigned MAX_REPEATS = nir_pkg::MaxRepeatsDefault
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  nir_pkg::req_t  req,
  output logic           strobe,
  output nir_pkg::res_t  res
);
  import nir_pkg::*;

  localparam int unsigned RptW = $clog2(MAX_REPEATS + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BITS,
    S_CLOSE,
    S_RHDR,
    S_RMARK
  } state_t;

  state_t          state;
  logic [RptW-1:0] rem;
  logic            accept;
  logic            too_many;
  logic [7:0]      second_byte;
  logic [DataBits-1:0] word;
  sh_ctl_t         sh_ctl;
  sh_stat_t        sh_stat;

  assign accept      = start && (state == S_IDLE);
  assign busy        = (state != S_IDLE);
  assign too_many    = (req.repeats > 8'(MAX_REPEATS));
  assign second_byte = req.extended ? req.address[15:8] : ~req.address[7:0];
  assign word        = {~req.command, req.command, second_byte, req.address[7:0]};

  assign sh_ctl.load  = accept && !too_many;
  assign sh_ctl.shift = (state == S_BITS);

  nir_shift u_shift (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sh_ctl),
    .word (word),
    .stat (sh_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      rem    <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            strobe <= 1'b1;
            if (too_many) begin
              res <= '{mark_units: '0, space_units: '0, last: 1'b1, error: 1'b1};
            end else begin
              res   <= '{mark_units: HdrMark, space_units: HdrSpace,
                         last: 1'b0, error: 1'b0};
              rem   <= req.repeats[RptW-1:0];
              state <= S_BITS;
            end
          end
        end
        S_BITS: begin
          strobe <= 1'b1;
          res    <= '{mark_units: BitMark,
                      space_units: sh_stat.data_bit ? OneSpace : ZeroSpace,
                      last: 1'b0, error: 1'b0};
          if (sh_stat.final_bit) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          strobe <= 1'b1;
          if (rem == '0) begin
            res   <= '{mark_units: BitMark, space_units: '0, last: 1'b1, error: 1'b0};
            state <= S_IDLE;
          end else begin
            res   <= '{mark_units: BitMark, space_units: FirstGap,
                       last: 1'b0, error: 1'b0};
            state <= S_RHDR;
          end
        end
        S_RHDR: begin
          strobe <= 1'b1;
          res    <= '{mark_units: HdrMark, space_units: RptSpace, last: 1'b0, error: 1'b0};
          state  <= S_RMARK;
        end
        S_RMARK: begin
          strobe <= 1'b1;
          rem    <= rem - 1'b1;
          if (rem == RptW'(1)) begin
            res   <= '{mark_units: BitMark, space_units: '0, last: 1'b1, error: 1'b0};
            state <= S_IDLE;
          end else begin
            res   <= '{mark_units: BitMark, space_units: LaterGap,
                       last: 1'b0, error: 1'b0};
            state <= S_RHDR;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (busy == !res.last))
    else $error("busy does not match the last flag of the emitted pair");

  a_accept_emits: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe)
    else $error("accepted request produced no pair in the next cycle");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.error) |-> (res.last && (res.mark_units == '0) && !busy))
    else $error("error result is malformed or the block stayed busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    sh_ctl.load |=> (state == S_BITS))
    else $error("data shift register loaded without entering the bit phase");

endmodule

`default_nettype wire
